// ----- rtl/core/tcce_pkg.sv -----
// Shared types, constants and helpers for the text console cursor engine.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package tcce_pkg;

  // Cell geometry and tab expansion
  localparam int GLYPH_WIDTH  = 8;
  localparam int GLYPH_HEIGHT = 16;
  localparam int TAB_SPACES   = 8;

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int ROW_W   = 7;
  localparam int COL_W   = 9;
  localparam int ROWS_W  = 8;
  localparam int X_W     = 12;
  localparam int Y_W     = 11;
  localparam int COLOR_W = 24;
  localparam int CNT_W   = $clog2(TAB_SPACES + 1);

  // Screen size limits
  localparam logic [ROWS_W-1:0] ROW_MIN = 8'd2;
  localparam logic [ROWS_W-1:0] ROW_MAX = 8'd128;
  localparam logic [COL_W-1:0]  COL_MIN = 9'd8;
  localparam logic [COL_W-1:0]  COL_MAX = 9'd256;

  // Character codes
  localparam logic [CHAR_W-1:0] CHAR_BS    = 8'd8;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_NL    = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

  localparam logic [COLOR_W-1:0] CURSOR_BACK = 24'hC0C0C0;

  // Configuration register indexes and reset values
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR   = 2'd2;

  localparam logic [ROWS_W-1:0]  RST_ROW_COUNT    = 8'd64;
  localparam logic [COL_W-1:0]   RST_COLUMN_COUNT = 9'd96;
  localparam logic [COLOR_W-1:0] RST_TEXT_COLOR   = 24'hC0C0C0;
  localparam logic [ROW_W-1:0]   RST_CURSOR_ROW   = 7'd1;

  // Request queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PRINT,
    OP_NEWLINE,
    OP_BACKSPACE
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [CHAR_W-1:0] glyph;
    logic [CNT_W-1:0]  count;
  } op_t;

  typedef enum logic [1:0] {
    CMD_GLYPH  = 2'd0,
    CMD_CURSOR = 2'd1,
    CMD_SCROLL = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    PH_NOP,
    PH_NL_ERASE_PRE,
    PH_NL_SCROLL,
    PH_NL_ERASE,
    PH_NL_DRAW,
    PH_GLYPH,
    PH_CURSOR,
    PH_BS_ERASE_OLD,
    PH_BS_ERASE_NEW,
    PH_BS_DRAW
  } phase_t;

  typedef struct packed {
    logic [ROWS_W-1:0]  row_count;
    logic [COL_W-1:0]   column_count;
    logic [COLOR_W-1:0] text_color;
  } cfg_t;

  typedef struct packed {
    cmd_t               command;
    logic [X_W-1:0]     pixel_x;
    logic [Y_W-1:0]     pixel_y;
    logic [CHAR_W-1:0]  glyph;
    logic [COLOR_W-1:0] fore_color;
    logic [COLOR_W-1:0] back_color;
    logic               last;
  } result_t;

  function automatic logic [ROWS_W-1:0] eff_rows(input logic [ROWS_W-1:0] v);
    logic [ROWS_W-1:0] r;
    if (v < ROW_MIN) r = ROW_MIN;
    else if (v > ROW_MAX) r = ROW_MAX;
    else r = v;
    return r;
  endfunction

  function automatic logic [COL_W-1:0] eff_cols(input logic [COL_W-1:0] v);
    logic [COL_W-1:0] r;
    if (v < COL_MIN) r = COL_MIN;
    else if (v > COL_MAX) r = COL_MAX;
    else r = v;
    return r;
  endfunction

endpackage

// ----- rtl/core/tcce_front.sv -----
// Front end: takes character requests and classifies them into queue entries.
// Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_front
  import tcce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [CHAR_W-1:0] in_char_code,
  output logic              in_stall,
  output logic              push_valid,
  output op_t               push_op,
  input  logic              push_ready
);

  logic hold_valid_r, hold_valid_nxt;
  op_t  hold_op_r, hold_op_nxt;
  logic accept, pushed;

  assign in_stall   = hold_valid_r & ~push_ready;
  assign accept     = in_valid & ~in_stall;
  assign pushed     = hold_valid_r & push_ready;
  assign push_valid = hold_valid_r;
  assign push_op    = hold_op_r;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (accept) begin
      hold_valid_nxt = 1'b1;
    end else if (pushed) begin
      hold_valid_nxt = 1'b0;
    end
  end

  // Expand tab into a run of spaces; everything unrecognized prints.
  always_comb begin
    hold_op_nxt = hold_op_r;
    if (accept) begin
      case (in_char_code)
        CHAR_NL: begin
          hold_op_nxt.kind  = OP_NEWLINE;
          hold_op_nxt.glyph = '0;
          hold_op_nxt.count = CNT_W'(1);
        end
        CHAR_TAB: begin
          hold_op_nxt.kind  = OP_PRINT;
          hold_op_nxt.glyph = CHAR_SPACE;
          hold_op_nxt.count = CNT_W'(TAB_SPACES);
        end
        CHAR_BS: begin
          hold_op_nxt.kind  = OP_BACKSPACE;
          hold_op_nxt.glyph = '0;
          hold_op_nxt.count = CNT_W'(1);
        end
        default: begin
          hold_op_nxt.kind  = OP_PRINT;
          hold_op_nxt.glyph = in_char_code;
          hold_op_nxt.count = CNT_W'(1);
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hold_op_r <= hold_op_nxt;
  end

endmodule

// ----- rtl/core/tcce_queue.sv -----
// Short request queue between the front end and the command sequencer.
// Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_queue
  import tcce_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  input  op_t  push_op,
  output logic push_ready,
  output logic pop_valid,
  output op_t  pop_op,
  input  logic pop
);

  op_t               mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_op     = mem_r[rd_ptr_r];
  assign do_push    = push_valid & push_ready;
  assign do_pop     = pop & pop_valid;

  always_comb begin
    wr_ptr_nxt = do_push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = QCNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_op;
    end
  end

endmodule

// ----- rtl/core/tcce_back.sv -----
// Command sequencer: holds the cursor state and turns queued requests into drawing
// commands, one per unstalled cycle, via an output register. Depends on tcce_pkg.
`timescale 1ns / 1ps

module tcce_back
  import tcce_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    q_valid,
  input  op_t     q_op,
  output logic    q_pop,
  output logic    res_valid,
  output result_t res,
  input  logic    res_ready
);

  // Cursor state
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [X_W-1:0]   prev_x_r, prev_x_nxt;
  logic [Y_W-1:0]   prev_y_r, prev_y_nxt;

  // Request in progress
  logic   busy_r, busy_nxt;
  phase_t phase_r, phase_nxt;
  op_t    op_r, op_nxt;

  // Output register
  logic    res_valid_r, res_valid_nxt;
  result_t res_r, res_nxt;

  logic [ROWS_W-1:0] rows_eff;
  logic [COL_W-1:0]  cols_eff;
  op_t               cur_op;
  phase_t            cur_phase;
  logic              active, slot_free, fire, emit, done;
  result_t           cur_res;

  logic [X_W-1:0]    cell_x, glyph_cursor_x, bs_x;
  logic [Y_W-1:0]    cell_y, nl_y, bs_y;
  logic [ROWS_W-1:0] row_inc;
  logic [ROW_W-1:0]  nl_row, bs_row;
  logic [COL_W-1:0]  bs_col, col_inc;

  function automatic phase_t nl_start(input logic [ROW_W-1:0] row,
                                      input logic [ROWS_W-1:0] rows);
    phase_t p;
    if (ROWS_W'({1'b0, row} + 1'b1) >= rows) p = PH_NL_ERASE_PRE;
    else p = PH_NL_ERASE;
    return p;
  endfunction

  function automatic phase_t print_start(input logic [ROW_W-1:0] row,
                                         input logic [COL_W-1:0] col,
                                         input logic [ROWS_W-1:0] rows,
                                         input logic [COL_W-1:0] cols);
    phase_t p;
    if (col >= cols) p = nl_start(row, rows);
    else p = PH_GLYPH;
    return p;
  endfunction

  assign rows_eff = eff_rows(cfg.row_count);
  assign cols_eff = eff_cols(cfg.column_count);

  // Cell geometry from the current cursor
  always_comb begin
    cell_x         = X_W'(X_W'(col_r) * X_W'(GLYPH_WIDTH));
    cell_y         = Y_W'(Y_W'(row_r) * Y_W'(GLYPH_HEIGHT));
    glyph_cursor_x = X_W'(cell_x + X_W'(GLYPH_WIDTH + 1));
    row_inc        = ROWS_W'({1'b0, row_r} + 1'b1);
    nl_row         = (row_inc >= rows_eff) ? ROW_W'(rows_eff - 1'b1) : ROW_W'(row_inc);
    nl_y           = Y_W'(Y_W'(nl_row) * Y_W'(GLYPH_HEIGHT));
    col_inc        = COL_W'(col_r + 1'b1);
    if (col_r != '0) begin
      bs_row = row_r;
      bs_col = COL_W'(col_r - 1'b1);
    end else begin
      bs_row = ROW_W'(row_r - 1'b1);
      bs_col = COL_W'(cols_eff - 1'b1);
    end
    bs_x = X_W'(X_W'(bs_col) * X_W'(GLYPH_WIDTH));
    bs_y = Y_W'(Y_W'(bs_row) * Y_W'(GLYPH_HEIGHT));
  end

  // Pick the step to run: the held request, or the first step of the queue head
  always_comb begin
    cur_op = busy_r ? op_r : q_op;
    if (busy_r) begin
      cur_phase = phase_r;
    end else begin
      case (q_op.kind)
        OP_NEWLINE:   cur_phase = nl_start(row_r, rows_eff);
        OP_BACKSPACE: cur_phase = (row_r == '0 && col_r == '0) ? PH_NOP : PH_BS_ERASE_OLD;
        default:      cur_phase = print_start(row_r, col_r, rows_eff, cols_eff);
      endcase
    end
  end

  assign active    = busy_r | q_valid;
  assign slot_free = ~res_valid_r | res_ready;
  assign fire      = active & (slot_free | (cur_phase == PH_NOP));
  assign emit      = fire & (cur_phase != PH_NOP);
  assign q_pop     = fire & ~busy_r;

  // Next step and cursor updates
  always_comb begin
    phase_nxt  = phase_r;
    busy_nxt   = busy_r;
    op_nxt     = op_r;
    row_nxt    = row_r;
    col_nxt    = col_r;
    prev_x_nxt = prev_x_r;
    prev_y_nxt = prev_y_r;
    done       = 1'b0;
    if (fire) begin
      op_nxt   = cur_op;
      busy_nxt = 1'b1;
      case (cur_phase)
        PH_NL_ERASE_PRE: phase_nxt = PH_NL_SCROLL;
        PH_NL_SCROLL:    phase_nxt = PH_NL_ERASE;
        PH_NL_ERASE:     phase_nxt = PH_NL_DRAW;
        PH_NL_DRAW: begin
          row_nxt    = nl_row;
          col_nxt    = '0;
          prev_x_nxt = '0;
          prev_y_nxt = nl_y;
          // a wrap ahead of a print goes on to the glyph
          if (cur_op.kind == OP_NEWLINE) done = 1'b1;
          else phase_nxt = PH_GLYPH;
        end
        PH_GLYPH: phase_nxt = PH_CURSOR;
        PH_CURSOR: begin
          prev_x_nxt = glyph_cursor_x;
          prev_y_nxt = cell_y;
          col_nxt    = col_inc;
          if (cur_op.count == CNT_W'(1)) begin
            done = 1'b1;
          end else begin
            op_nxt.count = CNT_W'(cur_op.count - 1'b1);
            phase_nxt    = print_start(row_r, col_inc, rows_eff, cols_eff);
          end
        end
        PH_BS_ERASE_OLD: phase_nxt = PH_BS_ERASE_NEW;
        PH_BS_ERASE_NEW: phase_nxt = PH_BS_DRAW;
        PH_BS_DRAW: begin
          row_nxt    = bs_row;
          col_nxt    = bs_col;
          prev_x_nxt = bs_x;
          prev_y_nxt = bs_y;
          done       = 1'b1;
        end
        default: done = 1'b1;
      endcase
      if (done) busy_nxt = 1'b0;
    end
  end

  // Command fields for the current step
  always_comb begin
    cur_res            = '0;
    cur_res.command    = CMD_CURSOR;
    case (cur_phase)
      PH_NL_ERASE_PRE, PH_NL_ERASE: begin
        cur_res.pixel_x = prev_x_r;
        cur_res.pixel_y = prev_y_r;
      end
      PH_NL_SCROLL: cur_res.command = CMD_SCROLL;
      PH_NL_DRAW: begin
        cur_res.pixel_y    = nl_y;
        cur_res.back_color = CURSOR_BACK;
        cur_res.last       = (cur_op.kind == OP_NEWLINE);
      end
      PH_GLYPH: begin
        cur_res.command    = CMD_GLYPH;
        cur_res.pixel_x    = cell_x;
        cur_res.pixel_y    = cell_y;
        cur_res.glyph      = cur_op.glyph;
        cur_res.fore_color = cfg.text_color;
      end
      PH_CURSOR: begin
        cur_res.pixel_x    = glyph_cursor_x;
        cur_res.pixel_y    = cell_y;
        cur_res.back_color = CURSOR_BACK;
        cur_res.last       = (cur_op.count == CNT_W'(1));
      end
      PH_BS_ERASE_OLD: begin
        cur_res.pixel_x = cell_x;
        cur_res.pixel_y = cell_y;
      end
      PH_BS_ERASE_NEW: begin
        cur_res.pixel_x = bs_x;
        cur_res.pixel_y = bs_y;
      end
      PH_BS_DRAW: begin
        cur_res.pixel_x    = bs_x;
        cur_res.pixel_y    = bs_y;
        cur_res.back_color = CURSOR_BACK;
        cur_res.last       = 1'b1;
      end
      default: cur_res = '0;
    endcase
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    res_nxt       = res_r;
    if (slot_free) begin
      res_valid_nxt = emit;
      if (emit) res_nxt = cur_res;
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      phase_r     <= PH_NOP;
      row_r       <= RST_CURSOR_ROW;
      col_r       <= '0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      res_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      phase_r     <= phase_nxt;
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      prev_x_r    <= prev_x_nxt;
      prev_y_r    <= prev_y_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= op_nxt;
    res_r <= res_nxt;
  end

endmodule

// ----- rtl/core/text_console_cursor_engine_unit.sv -----
// Top level of the text console cursor engine: configuration registers and
// front end, request queue and command sequencer. Depends on tcce_pkg.
`timescale 1ns / 1ps

//  port group   direction  handshake          payload
//  in_*         input      in_valid/in_stall  in_char_code
//  out_*        output     out_valid/out_stall command, pixel_x/y, glyph, colors, last
//  cfg_*        input      cfg_wr_en          cfg_index, cfg_wdata
//
// One drawing command leaves per cycle while out_stall is low; the sequencer step is
// the pace setter. A byte draws its glyph, then the cursor; a newline moves the
// cursor, scrolling on the last row; a backspace moves it back, with no command at
// home; a tab prints eight spaces; a wrap runs a newline ahead of the glyph. Reset
// is synchronous on rst_n and needs no clearing pass. The front end keeps filling
// the 4-entry request queue while out_stall holds the output register.

module text_console_cursor_engine_unit
  import tcce_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic [CHAR_W-1:0]    in_char_code,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_command,
  output logic [X_W-1:0]       out_pixel_x,
  output logic [Y_W-1:0]       out_pixel_y,
  output logic [CHAR_W-1:0]    out_glyph,
  output logic [COLOR_W-1:0]   out_fore_color,
  output logic [COLOR_W-1:0]   out_back_color,
  output logic                 out_last,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COLOR_W-1:0]   cfg_wdata
);

  cfg_t    cfg_r, cfg_nxt;
  logic    push_valid, push_ready, pop_valid, pop;
  op_t     push_op, pop_op;
  result_t res;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_index)
        CFG_ROW_COUNT:    cfg_nxt.row_count    = cfg_wdata[ROWS_W-1:0];
        CFG_COLUMN_COUNT: cfg_nxt.column_count = cfg_wdata[COL_W-1:0];
        CFG_TEXT_COLOR:   cfg_nxt.text_color   = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_count    <= RST_ROW_COUNT;
      cfg_r.column_count <= RST_COLUMN_COUNT;
      cfg_r.text_color   <= RST_TEXT_COLOR;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  tcce_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_char_code (in_char_code),
    .in_stall     (in_stall),
    .push_valid   (push_valid),
    .push_op      (push_op),
    .push_ready   (push_ready)
  );

  tcce_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_op    (push_op),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_op     (pop_op),
    .pop        (pop)
  );

  tcce_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (pop_valid),
    .q_op      (pop_op),
    .q_pop     (pop),
    .res_valid (out_valid),
    .res       (res),
    .res_ready (~out_stall)
  );

  assign out_command    = res.command;
  assign out_pixel_x    = res.pixel_x;
  assign out_pixel_y    = res.pixel_y;
  assign out_glyph      = res.glyph;
  assign out_fore_color = res.fore_color;
  assign out_back_color = res.back_color;
  assign out_last       = res.last;

endmodule
